[hw/rtl/swm_pkg.sv]
package swm_pkg;

   // Sizing of the monitored region and of the sample scan.
   localparam int MAX_BYTES  = 4096;
   localparam int MIN_BYTES  = 16;
   localparam int SCAN_LIMIT = 256;

   localparam int ADDR_W = $clog2(MAX_BYTES);
   localparam int SIZE_W = $clog2(MAX_BYTES + 1);
   localparam int SEEN_W = $clog2(SCAN_LIMIT + 1);

   // Request kinds.
   localparam logic [1:0] REQ_ARM    = 2'd0;
   localparam logic [1:0] REQ_WRITE  = 2'd1;
   localparam logic [1:0] REQ_SAMPLE = 2'd2;

   // Response status codes.
   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_INVALID   = 3'd1;
   localparam logic [2:0] ST_OVERSIZE  = 3'd2;
   localparam logic [2:0] ST_ARMED     = 3'd3;
   localparam logic [2:0] ST_NOT_ARMED = 3'd4;
   localparam logic [2:0] ST_TIMEOUT   = 3'd5;

   // Register file.
   localparam logic       REG_FILL_PATTERN = 1'b0;
   localparam logic [7:0] FILL_RESET       = 8'd165;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [12:0] arm_bytes;
      logic [11:0] write_index;
      logic [7:0]  write_byte;
   } swm_req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [12:0] free_count;
      logic [12:0] minimum_free;
      logic        snapshot_valid;
   } swm_rsp_type;

   // Write port of the region memory.
   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
      logic [7:0]        data;
   } swm_wr_type;

endpackage

[hw/rtl/stack_watermark_monitor.sv]
// Stack high-water monitor over a 4096-byte region memory.
// Items arrive on the req_ channel (valid/ready) and each one yields exactly
// one response item on the rsp_ channel (valid/ready), in order.
// A successful arm item paints the first arm_bytes bytes of the region with
// the fill pattern, one byte per cycle; a write item stores one byte if its
// index lies below the armed size; a sample item scans down from the lowest
// free count for the first byte still holding the pattern.
// A sample reads one byte per cycle through the single read port, with the
// compare in the cycle after the read.
// req_ready is high only while the sequencer is idle, so one item is at
// work at a time; the next one can be taken in the cycle after the result
// moves out.
// The response sits in its own output register: when the receiver stalls,
// the next item is accepted and processed, and it waits before delivery
// until that register is taken.
// The fill_pattern register is written over the csr_ APB port at any address with csr_paddr[2] clear.
// Reset clears the armed flag, the sizes and the pending response, and sets
// the pattern to 165; the region memory is not cleared.
module stack_watermark_monitor
   import swm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  swm_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output swm_rsp_type rsp_data,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_FILL = 4'b0010,
      S_SCAN = 4'b0100,
      S_DONE = 4'b1000
   } state_type;

   state_type         state_ff, state_in;
   logic [SIZE_W-1:0] cursor_ff, cursor_in;
   logic [SEEN_W-1:0] seen_ff, seen_in;
   logic              pend_ff, pend_in;
   logic [SIZE_W-1:0] fill_ff, fill_in;
   logic [SIZE_W-1:0] armed_size_ff, armed_size_in;
   logic [SIZE_W-1:0] lowest_free_ff, lowest_free_in;
   logic              is_armed_ff, is_armed_in;
   logic [7:0]        fill_pattern_ff;
   swm_rsp_type       result_ff, result_in;
   swm_rsp_type       rsp_ff;
   logic              rsp_valid_ff;

   swm_wr_type        mem_wr;
   logic [ADDR_W-1:0] mem_rd_addr;
   logic [7:0]        mem_rd_data;
   logic              req_fire;
   logic              out_free;
   logic [SIZE_W-1:0] cursor_dec;
   logic [SIZE_W-1:0] found_free;
   logic              csr_write;

   swm_region_mem u_mem (
      .clock   (clock),
      .wr      (mem_wr),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   assign req_ready  = (state_ff == S_IDLE);
   assign req_fire   = req_valid && req_ready;
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign cursor_dec = cursor_ff - SIZE_W'(1);
   assign found_free = cursor_ff + SIZE_W'(1);

   // Sequencer: decode in idle, paint in fill, compare and read in scan, wait for the output register in done.
   always_comb begin
      state_in       = state_ff;
      cursor_in      = cursor_ff;
      seen_in        = seen_ff;
      pend_in        = 1'b0;
      fill_in        = fill_ff;
      armed_size_in  = armed_size_ff;
      lowest_free_in = lowest_free_ff;
      is_armed_in    = is_armed_ff;
      result_in      = result_ff;
      mem_wr.en      = 1'b0;
      mem_wr.addr    = fill_ff[ADDR_W-1:0];
      mem_wr.data    = fill_pattern_ff;
      mem_rd_addr    = cursor_dec[ADDR_W-1:0];

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               result_in = '0;
               result_in.status = ST_OK;
               state_in = S_DONE;
               unique case (req_data.req_type)
                  REQ_ARM: begin
                     if (req_data.arm_bytes < SIZE_W'(MIN_BYTES)) begin
                        result_in.status = ST_INVALID;
                     end else if (req_data.arm_bytes > SIZE_W'(MAX_BYTES)) begin
                        result_in.status = ST_OVERSIZE;
                     end else if (is_armed_ff) begin
                        result_in.status = ST_ARMED;
                     end else begin
                        armed_size_in  = req_data.arm_bytes;
                        lowest_free_in = req_data.arm_bytes;
                        is_armed_in    = 1'b1;
                        fill_in        = '0;
                        state_in       = S_FILL;
                     end
                  end
                  REQ_WRITE: begin
                     mem_wr.addr = req_data.write_index[ADDR_W-1:0];
                     mem_wr.data = req_data.write_byte;
                     mem_wr.en   = SIZE_W'(req_data.write_index) < armed_size_ff;
                  end
                  REQ_SAMPLE: begin
                     if (!is_armed_ff) begin
                        result_in.status = ST_NOT_ARMED;
                     end else begin
                        cursor_in = lowest_free_ff;
                        seen_in   = '0;
                        state_in  = S_SCAN;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_FILL: begin
            // Paint one byte per cycle up to the armed size.
            mem_wr.en = 1'b1;
            fill_in   = fill_ff + SIZE_W'(1);
            if (fill_in == armed_size_ff) begin
               state_in = S_DONE;
            end
         end
         S_SCAN: begin
            // The byte read last cycle sits at the cursor; check it before
            // deciding whether to read the next one down.
            if (pend_ff && (mem_rd_data == fill_pattern_ff)) begin
               result_in.status         = ST_OK;
               result_in.free_count     = found_free;
               result_in.snapshot_valid = 1'b1;
               if (found_free < lowest_free_ff) begin
                  lowest_free_in = found_free;
               end
               result_in.minimum_free = lowest_free_in;
               state_in = S_DONE;
            end else if (cursor_ff == '0) begin
               lowest_free_in           = '0;
               result_in.status         = ST_OK;
               result_in.free_count     = '0;
               result_in.minimum_free   = '0;
               result_in.snapshot_valid = 1'b1;
               state_in = S_DONE;
            end else if (seen_ff == SEEN_W'(SCAN_LIMIT)) begin
               result_in.status = ST_TIMEOUT;
               state_in = S_DONE;
            end else begin
               cursor_in = cursor_dec;
               seen_in   = seen_ff + SEEN_W'(1);
               pend_in   = 1'b1;
            end
         end
         S_DONE: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Sequencer and monitor state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         pend_ff        <= 1'b0;
         armed_size_ff  <= '0;
         lowest_free_ff <= '0;
         is_armed_ff    <= 1'b0;
      end else begin
         state_ff       <= state_in;
         pend_ff        <= pend_in;
         armed_size_ff  <= armed_size_in;
         lowest_free_ff <= lowest_free_in;
         is_armed_ff    <= is_armed_in;
      end
   end

   // Working registers of the current item.
   always_ff @(posedge clock) begin
      cursor_ff <= cursor_in;
      seen_ff   <= seen_in;
      fill_ff   <= fill_in;
      result_ff <= result_in;
   end

   // Output register: a finished item moves here once it is free.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if ((state_ff == S_DONE) && out_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if ((state_ff == S_DONE) && out_free) begin
         rsp_ff <= result_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Configuration register.
   assign csr_write = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_pattern_ff <= FILL_RESET;
      end else if (csr_write && (csr_paddr[2] == REG_FILL_PATTERN)) begin
         fill_pattern_ff <= csr_pwdata[7:0];
      end
   end

   assign csr_prdata = (csr_paddr[2] == REG_FILL_PATTERN) ? {24'd0, fill_pattern_ff} : 32'd0;
   assign csr_pready = 1'b1;

endmodule

[hw/rtl/swm_region_mem.sv]
module swm_region_mem
   import swm_pkg::*;
(
   input  logic              clock,
   input  swm_wr_type        wr,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [7:0]        rd_data
);

   logic [7:0] mem_ff [MAX_BYTES];
   logic [7:0] rd_data_ff;

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem_ff[wr.addr] <= wr.data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
